>>> hdl/quadratic_root_solver_defines.svh
// assertion macros for the quadratic root solver
// needs clk_i and rst_ni in the scope of each use
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("qrs assertion failed");
`define QRS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qrs implication failed");
`else
`define QRS_ASSERT(name, prop)
`define QRS_ASSERT_IMPL(name, ante, cons)
`endif
`endif

>>> hdl/qrs_pkg.sv
// types and widths shared by the quadratic root solver
// no dependencies
package qrs_pkg;

  localparam int unsigned COEF_W    = 24;
  localparam int unsigned ROOT_OUT_W = 32;
  localparam int unsigned DISC_W    = 50;
  localparam int unsigned RAD_W     = 50;
  localparam int unsigned SQ_STEPS  = RAD_W / 2;
  localparam int unsigned ROOT_W    = SQ_STEPS;
  localparam int unsigned SQREM_W   = ROOT_W + 2;
  localparam int unsigned FIX_W     = COEF_W + 1;
  localparam int unsigned NUM_W     = ROOT_W + 2;
  localparam int unsigned MAG_W     = NUM_W - 1;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned QD_W      = MAG_W + FRAC_W;
  localparam int unsigned DIV_STEPS = QD_W;
  localparam int unsigned LANES     = 2;

  typedef enum logic [2:0] {
    KIND_NO_ROOT  = 3'd0,
    KIND_ALL_REAL = 3'd1,
    KIND_LINEAR   = 3'd2,
    KIND_NO_REAL  = 3'd3,
    KIND_DOUBLE   = 3'd4,
    KIND_TWO      = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [FIX_W-1:0] nfix;
    logic [FIX_W-1:0] den;
  } sq_meta_t;

  typedef struct packed {
    kind_e            kind;
    logic [LANES-1:0] neg;
  } div_meta_t;

endpackage

>>> hdl/qrs_front.sv
// products, discriminant and classification (two stages)
// depends on qrs_pkg
module qrs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_a_i,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_b_i,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_c_i,
  output logic                         valid_o,
  output qrs_pkg::sq_meta_t            meta_o,
  output logic [qrs_pkg::RAD_W-1:0]    rad_o
);

  logic                                  v1_q, v2_q;
  logic signed [2*qrs_pkg::COEF_W-1:0]   bb_q, ac_q;
  logic signed [qrs_pkg::FIX_W-1:0]      a2_q, b_q, c_q;
  logic                                  az_q, bz_q, cz_q;
  logic signed [qrs_pkg::DISC_W-1:0]     disc;
  qrs_pkg::kind_e                        kind;
  qrs_pkg::sq_meta_t                     meta_d, meta_q;
  logic [qrs_pkg::RAD_W-1:0]             rad_d, rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q   <= coef_b_i * coef_b_i;
      ac_q   <= coef_a_i * coef_c_i;
      a2_q   <= {coef_a_i, 1'b0};
      b_q    <= qrs_pkg::FIX_W'(coef_b_i);
      c_q    <= qrs_pkg::FIX_W'(coef_c_i);
      az_q   <= (coef_a_i == '0);
      bz_q   <= (coef_b_i == '0);
      cz_q   <= (coef_c_i == '0);
      meta_q <= meta_d;
      rad_q  <= rad_d;
    end
  end

  always_comb begin
    disc = qrs_pkg::DISC_W'(bb_q) - (qrs_pkg::DISC_W'(ac_q) <<< 2);
    if (az_q) begin
      if (bz_q) begin
        kind = cz_q ? qrs_pkg::KIND_ALL_REAL : qrs_pkg::KIND_NO_ROOT;
      end else begin
        kind = qrs_pkg::KIND_LINEAR;
      end
    end else if (disc < 0) begin
      kind = qrs_pkg::KIND_NO_REAL;
    end else if (disc == '0) begin
      kind = qrs_pkg::KIND_DOUBLE;
    end else begin
      kind = qrs_pkg::KIND_TWO;
    end
    meta_d.kind = kind;
    meta_d.nfix = (kind == qrs_pkg::KIND_LINEAR) ? -c_q : -b_q;
    meta_d.den  = (kind == qrs_pkg::KIND_LINEAR) ? b_q : a2_q;
    rad_d       = (kind == qrs_pkg::KIND_TWO) ? qrs_pkg::RAD_W'(disc) : '0;
  end

  assign valid_o = v2_q;
  assign meta_o  = meta_q;
  assign rad_o   = rad_q;

endmodule

>>> hdl/qrs_sqrt.sv
// pipelined floor square root, one result bit per stage
// depends on qrs_pkg
module qrs_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  qrs_pkg::sq_meta_t           meta_i,
  input  logic [qrs_pkg::RAD_W-1:0]   rad_i,
  output logic                        valid_o,
  output qrs_pkg::sq_meta_t           meta_o,
  output logic [qrs_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned N = qrs_pkg::SQ_STEPS;

  logic                          v_q    [N];
  qrs_pkg::sq_meta_t             meta_q [N];
  logic [qrs_pkg::SQREM_W-1:0]   rem_q  [N];
  logic [qrs_pkg::ROOT_W-1:0]    root_q [N];
  logic [qrs_pkg::RAD_W-1:0]     rad_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                          v_in;
    qrs_pkg::sq_meta_t             m_in;
    logic [qrs_pkg::SQREM_W-1:0]   rem_in;
    logic [qrs_pkg::ROOT_W-1:0]    root_in;
    logic [qrs_pkg::RAD_W-1:0]     rad_in;
    logic [qrs_pkg::SQREM_W:0]     cur, trial;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign m_in    = meta_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign m_in    = meta_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    assign cur   = {rem_in[qrs_pkg::SQREM_W-2:0], rad_in[qrs_pkg::RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        meta_q[i] <= m_in;
        rad_q[i]  <= {rad_in[qrs_pkg::RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
          rem_q[i]  <= qrs_pkg::SQREM_W'(cur - trial);
          root_q[i] <= {root_in[qrs_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= qrs_pkg::SQREM_W'(cur);
          root_q[i] <= {root_in[qrs_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign meta_o  = meta_q[N-1];
  assign root_o  = root_q[N-1];

endmodule

>>> hdl/qrs_div.sv
// two-lane pipelined restoring divider, one quotient bit per stage
// depends on qrs_pkg
module qrs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  qrs_pkg::sq_meta_t           meta_i,
  input  logic [qrs_pkg::ROOT_W-1:0]  root_i,
  output logic                        valid_o,
  output qrs_pkg::div_meta_t          meta_o,
  output logic [qrs_pkg::QD_W-1:0]    quot_o [qrs_pkg::LANES]
);

  localparam int unsigned N  = qrs_pkg::DIV_STEPS;
  localparam int unsigned L  = qrs_pkg::LANES;
  localparam int unsigned DW = qrs_pkg::FIX_W;

  logic signed [qrs_pkg::NUM_W-1:0] num [L];
  logic [qrs_pkg::NUM_W-1:0]        num_neg [L];
  logic [DW-1:0]                    den_neg;
  qrs_pkg::div_meta_t               pm_d;

  logic                       pv_q;
  qrs_pkg::div_meta_t         pm_q;
  logic [DW-1:0]              pden_q;
  logic [qrs_pkg::QD_W-1:0]   pqd_q [L];

  logic                       v_q   [N];
  qrs_pkg::div_meta_t         m_q   [N];
  logic [DW-1:0]              den_q [N];
  logic [qrs_pkg::QD_W-1:0]   qd_q  [N][L];
  logic [DW-1:0]              rem_q [N][L];

  always_comb begin
    pm_d.kind = meta_i.kind;
    den_neg   = -meta_i.den;
    for (int l = 0; l < L; l++) begin
      if (l == 0) begin
        num[l] = $signed(qrs_pkg::NUM_W'($signed(meta_i.nfix)))
               - $signed(qrs_pkg::NUM_W'(root_i));
      end else begin
        num[l] = $signed(qrs_pkg::NUM_W'($signed(meta_i.nfix)))
               + $signed(qrs_pkg::NUM_W'(root_i));
      end
      num_neg[l]  = -num[l];
      pm_d.neg[l] = num[l][qrs_pkg::NUM_W-1] ^ meta_i.den[DW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q   <= pm_d;
      pden_q <= meta_i.den[DW-1] ? den_neg : meta_i.den;
      for (int l = 0; l < L; l++) begin
        pqd_q[l] <= {(num[l][qrs_pkg::NUM_W-1] ? num_neg[l][qrs_pkg::MAG_W-1:0]
                                               : num[l][qrs_pkg::MAG_W-1:0]),
                     {qrs_pkg::FRAC_W{1'b0}}};
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                     v_in;
    qrs_pkg::div_meta_t       m_in;
    logic [DW-1:0]            den_in;
    logic [qrs_pkg::QD_W-1:0] qd_in  [L];
    logic [DW-1:0]            rem_in [L];
    logic [DW:0]              cur    [L];
    logic [L-1:0]             ge;

    if (i == 0) begin : g_first
      assign v_in   = pv_q;
      assign m_in   = pm_q;
      assign den_in = pden_q;
      for (genvar l = 0; l < L; l++) begin : g_lane_in
        assign qd_in[l]  = pqd_q[l];
        assign rem_in[l] = '0;
      end
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign m_in   = m_q[i-1];
      assign den_in = den_q[i-1];
      for (genvar l = 0; l < L; l++) begin : g_lane_in
        assign qd_in[l]  = qd_q[i-1][l];
        assign rem_in[l] = rem_q[i-1][l];
      end
    end

    for (genvar l = 0; l < L; l++) begin : g_lane
      assign cur[l] = {rem_in[l], qd_in[l][qrs_pkg::QD_W-1]};
      assign ge[l]  = (cur[l] >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i]   <= m_in;
        den_q[i] <= den_in;
        for (int l = 0; l < L; l++) begin
          qd_q[i][l]  <= {qd_in[l][qrs_pkg::QD_W-2:0], ge[l]};
          rem_q[i][l] <= ge[l] ? DW'(cur[l] - {1'b0, den_in}) : DW'(cur[l]);
        end
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign meta_o  = m_q[N-1];
  for (genvar l = 0; l < L; l++) begin : g_out
    assign quot_o[l] = qd_q[N-1][l];
  end

endmodule

>>> hdl/quadratic_root_solver.sv
// quadratic root solver top level: front end, square root, divider, output register
// depends on qrs_pkg, qrs_front, qrs_sqrt, qrs_div and the assertion macro header
//
// usage:
//   input channel: coef_a_i, coef_b_i, coef_c_i (signed Q8.16) with in_valid_i,
//   in_stall_o. output channel: solution_kind_o, root_first_o, root_second_o
//   (signed Q16.16) and saturated_o with out_valid_o, out_stall_i.
//   one item in, one item out, in order.
//   from acceptance to out_valid_o an item passes two stages for the
//   products and discriminant, 25 square root stages, one divider set-up stage,
//   42 divider stages and the output register.
//   throughput is one item per cycle unless the receiver stalls; the root and
//   quotient are computed one bit per pipeline stage, so stages never iterate.
//   when the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall_o is raised in the same cycle; nothing is dropped or repeated.
//   reset clears all valid bits; the pipeline is empty and ready right after.
`include "quadratic_root_solver_defines.svh"
module quadratic_root_solver (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic signed [qrs_pkg::COEF_W-1:0]         coef_a_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]         coef_b_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]         coef_c_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic [2:0]                                solution_kind_o,
  output logic signed [qrs_pkg::ROOT_OUT_W-1:0]     root_first_o,
  output logic signed [qrs_pkg::ROOT_OUT_W-1:0]     root_second_o,
  output logic                                      saturated_o
);

  localparam int unsigned RW = qrs_pkg::ROOT_OUT_W;
  localparam logic [RW-1:0] R_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic [RW-1:0] R_MIN = {1'b1, {(RW-1){1'b0}}};

  function automatic logic [RW:0] sat_root(input logic [qrs_pkg::QD_W-1:0] mag,
                                           input logic neg);
    logic [RW-1:0] low_neg;
    logic          over;
    low_neg = -mag[RW-1:0];
    if (neg) begin
      over = (mag[qrs_pkg::QD_W-1:RW] != '0) || (mag[RW-1] && (mag[RW-2:0] != '0));
      sat_root = over ? {1'b1, R_MIN} : {1'b0, low_neg};
    end else begin
      over = (mag[qrs_pkg::QD_W-1:RW-1] != '0);
      sat_root = over ? {1'b1, R_MAX} : {1'b0, mag[RW-1:0]};
    end
  endfunction

  logic                        adv;
  logic                        f_valid, s_valid, d_valid;
  qrs_pkg::sq_meta_t           f_meta, s_meta;
  logic [qrs_pkg::RAD_W-1:0]   f_rad;
  logic [qrs_pkg::ROOT_W-1:0]  s_root;
  qrs_pkg::div_meta_t          d_meta;
  logic [qrs_pkg::QD_W-1:0]    d_quot [qrs_pkg::LANES];
  logic [RW:0]                 r1, r2;

  logic                        out_valid_q;
  qrs_pkg::kind_e              kind_d, kind_q;
  logic [RW-1:0]               first_d, first_q, second_d, second_q;
  logic                        sat_d, sat_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  qrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (in_valid_i),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .valid_o  (f_valid),
    .meta_o   (f_meta),
    .rad_o    (f_rad)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_valid),
    .meta_i  (f_meta),
    .rad_i   (f_rad),
    .valid_o (s_valid),
    .meta_o  (s_meta),
    .root_o  (s_root)
  );

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_valid),
    .meta_i  (s_meta),
    .root_i  (s_root),
    .valid_o (d_valid),
    .meta_o  (d_meta),
    .quot_o  (d_quot)
  );

  always_comb begin
    r1       = sat_root(d_quot[0], d_meta.neg[0]);
    r2       = sat_root(d_quot[1], d_meta.neg[1]);
    kind_d   = d_meta.kind;
    first_d  = '0;
    second_d = '0;
    sat_d    = 1'b0;
    case (d_meta.kind)
      qrs_pkg::KIND_LINEAR, qrs_pkg::KIND_DOUBLE: begin
        first_d = r1[RW-1:0];
        sat_d   = r1[RW];
      end
      qrs_pkg::KIND_TWO: begin
        first_d  = r1[RW-1:0];
        second_d = r2[RW-1:0];
        sat_d    = r1[RW] | r2[RW];
      end
      default: begin
        first_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && d_valid) begin
      kind_q   <= kind_d;
      first_q  <= first_d;
      second_q <= second_d;
      sat_q    <= sat_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign solution_kind_o = kind_q;
  assign root_first_o    = first_q;
  assign root_second_o   = second_q;
  assign saturated_o     = sat_q;

  `QRS_ASSERT_IMPL(a_no_roots_zero, out_valid_q && (kind_q == qrs_pkg::KIND_NO_ROOT || kind_q == qrs_pkg::KIND_ALL_REAL || kind_q == qrs_pkg::KIND_NO_REAL), first_q == '0 && second_q == '0 && !sat_q)
  `QRS_ASSERT_IMPL(a_second_only_two, out_valid_q && kind_q != qrs_pkg::KIND_TWO, second_q == '0)
  `QRS_ASSERT_IMPL(a_sat_at_limit, out_valid_q && sat_q, first_q == R_MAX || first_q == R_MIN || second_q == R_MAX || second_q == R_MIN)
  `QRS_ASSERT_IMPL(a_hold_when_stalled, out_valid_q && out_stall_i, ##1 out_valid_q && $stable(kind_q) && $stable(first_q))

endmodule
